// ----- hw/rtl/fqv_pkg.sv -----
package fqv_pkg;

	// width of the line length counters
	localparam int LENGTH_BITS = 16;

	// character codes
	localparam logic [7:0] CHAR_NL    = 8'd10;
	localparam logic [7:0] CHAR_GT    = 8'd62;
	localparam logic [7:0] CHAR_AT    = 8'd64;
	localparam logic [7:0] CHAR_BANG  = 8'd33;
	localparam logic [7:0] CHAR_TILDE = 8'd126;
	localparam logic [7:0] CHAR_UA    = 8'd65;
	localparam logic [7:0] CHAR_UC    = 8'd67;
	localparam logic [7:0] CHAR_UG    = 8'd71;
	localparam logic [7:0] CHAR_UN    = 8'd78;
	localparam logic [7:0] CHAR_UT    = 8'd84;
	localparam logic [7:0] CHAR_LA    = 8'd97;
	localparam logic [7:0] CHAR_LZ    = 8'd122;
	localparam logic [7:0] CASE_DIFF  = 8'd32;

	// record formats
	localparam logic FMT_FASTA = 1'b0;
	localparam logic FMT_FASTQ = 1'b1;

	// error codes
	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_HEADER  = 3'd1,
		ERR_BASE    = 3'd2,
		ERR_LENGTH  = 3'd3,
		ERR_QUALITY = 3'd4
	} fqv_err_t;

	// fastq line number within a record
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_SEQ    = 2'd1,
		PH_PLUS   = 2'd2,
		PH_QUAL   = 2'd3
	} fqv_phase_t;

	// one input beat
	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} fqv_item_t;

	// one result beat
	typedef struct packed {
		logic     content_valid;
		fqv_err_t error_kind;
	} fqv_result_t;

	// parser state
	typedef struct packed {
		fqv_phase_t             line_phase;
		logic                   at_line_start;
		logic                   fasta_header_due;
		logic [LENGTH_BITS-1:0] read_length;
		logic [LENGTH_BITS-1:0] quality_length;
		logic                   checking_stopped;
		fqv_err_t               first_error;
	} fqv_state_t;

	localparam fqv_state_t STATE_RESET = '{
		line_phase:       PH_HEADER,
		at_line_start:    1'b1,
		fasta_header_due: 1'b1,
		read_length:      '0,
		quality_length:   '0,
		checking_stopped: 1'b0,
		first_error:      ERR_NONE
	};

endpackage

// ----- hw/rtl/fqv_core.sv -----
module fqv_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               file_format,
	input  logic               fire,
	input  fqv_pkg::fqv_item_t item,
	output logic               res_valid,
	output fqv_pkg::fqv_result_t res
);
	import fqv_pkg::*;

	fqv_state_t state_q;
	fqv_state_t after_byte;
	fqv_state_t after_last;
	fqv_state_t state_next;

	function automatic fqv_state_t note_error(fqv_state_t st, fqv_err_t kind, logic halt);
		fqv_state_t r;
		r = st;
		if (r.first_error == ERR_NONE) begin
			r.first_error = kind;
		end
		if (halt) begin
			r.checking_stopped = 1'b1;
		end
		return r;
	endfunction

	function automatic logic is_base(logic [7:0] b);
		logic [7:0] u;
		u = (b >= CHAR_LA && b <= CHAR_LZ) ? b - CASE_DIFF : b;
		return u == CHAR_UA || u == CHAR_UC || u == CHAR_UG || u == CHAR_UT || u == CHAR_UN;
	endfunction

	function automatic logic [LENGTH_BITS-1:0] count_up(logic [LENGTH_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic fqv_state_t end_line(fqv_state_t st, logic fmt);
		fqv_state_t r;
		r = st;
		if (!st.at_line_start) begin
			if (fmt == FMT_FASTQ) begin
				if (st.line_phase == PH_QUAL && st.quality_length != st.read_length) begin
					r = note_error(st, ERR_LENGTH, 1'b1);
				end else begin
					r.line_phase    = fqv_phase_t'(st.line_phase + 2'd1);
					r.at_line_start = 1'b1;
				end
			end else begin
				r.fasta_header_due = 1'b0;
				r.at_line_start    = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic fqv_state_t take_byte(fqv_state_t st, logic fmt, logic [7:0] b);
		fqv_state_t r;
		logic       first;
		r               = st;
		first           = st.at_line_start;
		r.at_line_start = 1'b0;
		if (fmt == FMT_FASTA) begin
			if (st.fasta_header_due) begin
				if (first && b != CHAR_GT) begin
					r = note_error(r, ERR_HEADER, 1'b1);
				end
			end else if (!is_base(b)) begin
				r = note_error(r, ERR_BASE, 1'b0);
			end
		end else begin
			case (st.line_phase)
				PH_HEADER: begin
					if (first && b != CHAR_AT) begin
						r = note_error(r, ERR_HEADER, 1'b1);
					end
				end
				PH_SEQ: begin
					r.read_length = count_up(first ? '0 : st.read_length);
					if (!is_base(b)) begin
						r = note_error(r, ERR_BASE, 1'b0);
					end
				end
				PH_PLUS: begin
					r = r;
				end
				default: begin
					r.quality_length = count_up(first ? '0 : st.quality_length);
					if (b < CHAR_BANG || b > CHAR_TILDE) begin
						r = note_error(r, ERR_QUALITY, 1'b0);
					end
				end
			endcase
		end
		return r;
	endfunction

	// per-byte update, then the implicit line end on the final byte
	always_comb begin
		after_byte = state_q;
		if (!state_q.checking_stopped) begin
			if (item.text_byte == CHAR_NL) begin
				after_byte = end_line(state_q, file_format);
			end else begin
				after_byte = take_byte(state_q, file_format, item.text_byte);
			end
		end
		after_last = after_byte;
		if (!after_byte.checking_stopped && item.text_byte != CHAR_NL) begin
			after_last = end_line(after_byte, file_format);
		end
		state_next = item.last_byte ? STATE_RESET : after_byte;
	end

	// result of the final beat
	assign res_valid         = fire && item.last_byte;
	assign res.content_valid = (after_last.first_error == ERR_NONE);
	assign res.error_kind    = after_last.first_error;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (fire) begin
			state_q <= state_next;
		end
	end

endmodule

// ----- hw/rtl/fqv_out_reg.sv -----
module fqv_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_valid,
	input  fqv_pkg::fqv_result_t res,
	output logic                 can_take,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output fqv_pkg::fqv_result_t m_res
);
	import fqv_pkg::*;

	logic        valid_q;
	fqv_result_t res_q;

	// slot is free when empty or draining this cycle
	assign can_take      = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_res         = res_q;

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

endmodule

// ----- hw/rtl/fastq_fasta_stream_validator.sv -----
// a final beat passes the input register, then the output register; its result is offered once the output is free
// throughput: one byte per cycle; stalls only while a result waits on the output register
// the per-byte parser update between the input register and state register sets the rate
// reset: arst_n asynchronously clears parser state, input and output valid, format to fasta
// after each final beat the parser state returns to its reset value; the format register stays
module fastq_fasta_stream_validator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
	input  logic       s_axis_tlast,   // last_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [0] content_valid, [3:1] error_kind, [7:4] zero
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data        // file_format
);
	import fqv_pkg::*;

	logic        file_format_q;
	logic        valid_s1;
	fqv_item_t   item_s1;
	logic        can_take;
	logic        fire;
	logic        res_valid;
	fqv_result_t res;
	fqv_result_t m_res;

	// format register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_format_q <= FMT_FASTA;
		end else if (cfg_valid) begin
			file_format_q <= cfg_data;
		end
	end

	// a final beat waits for the output slot, others go straight through
	assign fire          = valid_s1 && (!item_s1.last_byte || can_take);
	assign s_axis_tready = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.text_byte <= s_axis_tdata;
			item_s1.last_byte <= s_axis_tlast;
		end
	end

	fqv_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.file_format (file_format_q),
		.fire        (fire),
		.item        (item_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	fqv_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_valid     (res_valid),
		.res           (res),
		.can_take      (can_take),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_res         (m_res)
	);

	assign m_axis_tdata = {4'b0000, m_res.error_kind, m_res.content_valid};

endmodule

// ----- hw/rtl/fqv_checker.sv -----
module fqv_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       cfg_data
);
	import fqv_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// pass flag agrees with the error code
	a_pass_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[0] == (m_axis_tdata[3:1] == ERR_NONE))
		else $error("content_valid disagrees with error_kind");

	// only defined error codes and zero padding leave the block
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:4] == 4'b0000 &&
			(m_axis_tdata[3:1] == ERR_NONE || m_axis_tdata[3:1] == ERR_HEADER ||
			 m_axis_tdata[3:1] == ERR_BASE || m_axis_tdata[3:1] == ERR_LENGTH ||
			 m_axis_tdata[3:1] == ERR_QUALITY))
		else $error("undefined error code on result");

	// nothing is offered while reset is held
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

endmodule

bind fastq_fasta_stream_validator fqv_checker u_checker (.*);
